### sv/lle_pkg.sv
`default_nettype none
package lle_pkg;

  // default pool size
  localparam int unsigned POOL_NODES_DEF = 32;

  // request codes
  localparam logic [2:0] REQ_INS_HEAD  = 3'd0;
  localparam logic [2:0] REQ_INS_TAIL  = 3'd1;
  localparam logic [2:0] REQ_INS_POS   = 3'd2;
  localparam logic [2:0] REQ_DEL_FIRST = 3'd3;
  localparam logic [2:0] REQ_DEL_LAST  = 3'd4;
  localparam logic [2:0] REQ_DEL_POS   = 3'd5;

  // status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // controller states
  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CHECK, S_HEAD_WR, S_WALK, S_INS_B, S_INS_C,
    S_DEL_B, S_DEL_C, S_OUT
  } state_t;

  // datapath micro-operations, one per cycle
  typedef enum logic [3:0] {
    C_NONE, C_INIT_WR, C_ACCEPT, C_FINISH, C_RD_FREE, C_INS_HEAD,
    C_WALK_INIT, C_WALK, C_INS_A, C_INS_B, C_INS_C, C_DEL_H, C_DEL_A,
    C_DEL_B, C_DEL_C
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic init_last;
    logic is_ins;
    logic fail;
    logic head_path;
    logic walk_done;
  } dp_flags_t;

endpackage
`default_nettype wire

### sv/linked_list_engine_top.sv
`default_nettype none
// channel   direction  fields                                       handshake
// in_       input      req_type[2:0] item_value[31:0] position[5:0]  in_valid / in_stall
// out_      output     status[1:0] removed_value[31:0] list_length[5:0]  out_valid / out_stall
//
// one word at a time: head insert runs S_CHECK, S_HEAD_WR, S_OUT; head delete S_CHECK, S_DEL_B,
// S_DEL_C, S_OUT; unknown or failed S_CHECK, S_OUT; insert or delete behind list node k walks to
// node k, one link store read per walk step, then the B and C states; S_OUT waits out out_stall
// after reset an init pass writes one link per pool node to chain the free list, in_stall held
module linked_list_engine_top
  import lle_pkg::*;
#(
  parameter int unsigned POOL_NODES = POOL_NODES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [31:0] in_item_value,
  input  wire logic [5:0]  in_position,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [31:0]      out_removed_value,
  output logic [5:0]       out_list_length
);

  cmd_t      cmd;
  dp_flags_t flags;

  // sequencer
  lle_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .flags(flags), .cmd(cmd)
  );

  // list registers and node stores
  lle_dpath #(.POOL_NODES(POOL_NODES)) u_dpath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .flags(flags),
    .in_req_type(in_req_type), .in_item_value(in_item_value),
    .in_position(in_position), .out_status(out_status),
    .out_removed_value(out_removed_value), .out_list_length(out_list_length)
  );

endmodule
`default_nettype wire

### sv/lle_ram.sv
`default_nettype none
module lle_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/lle_ctrl.sv
`default_nettype none
module lle_ctrl
  import lle_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire dp_flags_t flags,
  output cmd_t           cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = C_NONE;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd = C_INIT_WR;
        if (flags.init_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd       = C_ACCEPT;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (flags.fail) begin
          cmd       = C_FINISH;
          state_nxt = S_OUT;
        end else if (flags.is_ins) begin
          if (flags.head_path) begin
            cmd       = C_RD_FREE;
            state_nxt = S_HEAD_WR;
          end else begin
            cmd       = C_WALK_INIT;
            state_nxt = S_WALK;
          end
        end else begin
          if (flags.head_path) begin
            cmd       = C_DEL_H;
            state_nxt = S_DEL_B;
          end else begin
            cmd       = C_WALK_INIT;
            state_nxt = S_WALK;
          end
        end
      end
      S_HEAD_WR: begin
        cmd       = C_INS_HEAD;
        state_nxt = S_OUT;
      end
      S_WALK: begin
        if (!flags.walk_done) begin
          cmd = C_WALK;
        end else if (flags.is_ins) begin
          cmd       = C_INS_A;
          state_nxt = S_INS_B;
        end else begin
          cmd       = C_DEL_A;
          state_nxt = S_DEL_B;
        end
      end
      S_INS_B: begin
        cmd       = C_INS_B;
        state_nxt = S_INS_C;
      end
      S_INS_C: begin
        cmd       = C_INS_C;
        state_nxt = S_OUT;
      end
      S_DEL_B: begin
        cmd       = C_DEL_B;
        state_nxt = S_DEL_C;
      end
      S_DEL_C: begin
        cmd       = C_DEL_C;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

endmodule
`default_nettype wire

### sv/lle_dpath.sv
`default_nettype none
module lle_dpath
  import lle_pkg::*;
#(
  parameter int unsigned POOL_NODES = POOL_NODES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output dp_flags_t        flags,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [31:0] in_item_value,
  input  wire logic [5:0]  in_position,
  output logic [1:0]       out_status,
  output logic [31:0]      out_removed_value,
  output logic [5:0]       out_list_length
);

  localparam int unsigned IW = $clog2(POOL_NODES + 1);
  localparam int unsigned AW = $clog2(POOL_NODES);
  localparam int unsigned CW = ((IW > 6) ? IW : 6) + 1;
  localparam logic [IW-1:0] NULL_IDX = IW'(POOL_NODES);

  logic [2:0]    req_r;
  logic [31:0]   val_r;
  logic [5:0]    pos_r;
  logic [IW-1:0] head_r, free_r, count_r, cur_r, aux_r, steps_r;
  logic [AW-1:0] init_r;
  logic          del_head_r;
  status_t       status_r;
  logic [31:0]   removed_r;
  logic [5:0]    len_r;

  logic          lk_we;
  logic [AW-1:0] lk_waddr, lk_raddr;
  logic [IW-1:0] lk_wdata, lk_rdata;
  logic          dt_we;
  logic [31:0]   dt_rdata;

  // link and data stores
  lle_ram #(.WIDTH(IW), .DEPTH(POOL_NODES)) u_link (
    .clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
    .raddr(lk_raddr), .rdata(lk_rdata)
  );
  lle_ram #(.WIDTH(32), .DEPTH(POOL_NODES)) u_data (
    .clk(clk), .we(dt_we), .waddr(free_r[AW-1:0]), .wdata(val_r),
    .raddr(aux_r[AW-1:0]), .rdata(dt_rdata)
  );

  // request decode and checks
  logic          is_ins, is_del, full, badpos_ins, badpos_del;
  logic [CW-1:0] posw, cntw, del_p, walk_k;
  status_t       err;

  always_comb begin
    posw   = CW'(pos_r);
    cntw   = CW'(count_r);
    is_ins = (req_r == REQ_INS_HEAD) || (req_r == REQ_INS_TAIL) || (req_r == REQ_INS_POS);
    is_del = (req_r == REQ_DEL_FIRST) || (req_r == REQ_DEL_LAST) || (req_r == REQ_DEL_POS);
    full   = (free_r >= NULL_IDX) || (count_r >= NULL_IDX);
    badpos_ins = (req_r == REQ_INS_POS) && ((posw < CW'(2)) || (posw > cntw + CW'(1)));
    badpos_del = (req_r == REQ_DEL_POS) && ((posw < CW'(1)) || (posw > cntw));
    err = ST_OK;
    if (is_ins && full)             err = ST_FULL;
    else if (is_ins && badpos_ins)  err = ST_BADPOS;
    else if (is_del && count_r == '0) err = ST_EMPTY;
    else if (is_del && badpos_del)  err = ST_BADPOS;
    if (req_r == REQ_DEL_FIRST)     del_p = CW'(1);
    else if (req_r == REQ_DEL_LAST) del_p = cntw;
    else                            del_p = posw;
    // node before the insertion or deletion point
    if (is_ins) walk_k = (req_r == REQ_INS_TAIL) ? cntw : posw - CW'(1);
    else        walk_k = del_p - CW'(1);
    flags.init_last = (init_r == AW'(POOL_NODES - 1));
    flags.is_ins    = is_ins;
    flags.fail      = !(is_ins || is_del) || (err != ST_OK);
    flags.head_path = is_ins ? ((req_r == REQ_INS_HEAD) || (count_r == '0))
                             : (del_p == CW'(1));
    flags.walk_done = (steps_r == '0);
  end

  // memory port steering
  always_comb begin
    lk_we    = 1'b0;
    lk_waddr = free_r[AW-1:0];
    lk_wdata = aux_r;
    lk_raddr = cur_r[AW-1:0];
    dt_we    = 1'b0;
    case (cmd)
      C_INIT_WR: begin
        lk_we    = 1'b1;
        lk_waddr = init_r;
        lk_wdata = IW'(init_r) + IW'(1);
      end
      C_RD_FREE:   lk_raddr = free_r[AW-1:0];
      C_INS_HEAD: begin
        lk_we    = 1'b1;
        lk_wdata = head_r;
        dt_we    = 1'b1;
      end
      C_WALK_INIT: lk_raddr = head_r[AW-1:0];
      C_WALK:      lk_raddr = lk_rdata[AW-1:0];
      C_INS_A:     lk_raddr = free_r[AW-1:0];
      C_INS_B: begin
        lk_we = 1'b1;
        dt_we = 1'b1;
      end
      C_INS_C: begin
        lk_we    = 1'b1;
        lk_waddr = cur_r[AW-1:0];
      end
      C_DEL_H:     lk_raddr = head_r[AW-1:0];
      C_DEL_A:     lk_raddr = lk_rdata[AW-1:0];
      C_DEL_B: begin
        lk_we    = !del_head_r;
        lk_waddr = cur_r[AW-1:0];
        lk_wdata = lk_rdata;
      end
      C_DEL_C: begin
        lk_we    = 1'b1;
        lk_waddr = aux_r[AW-1:0];
        lk_wdata = free_r;
      end
      default: ;
    endcase
  end

  // list control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= NULL_IDX;
      free_r  <= '0;
      count_r <= '0;
      init_r  <= '0;
      steps_r <= '0;
    end else begin
      case (cmd)
        C_INIT_WR:   init_r <= init_r + AW'(1);
        C_INS_HEAD: begin
          head_r  <= free_r;
          free_r  <= lk_rdata;
          count_r <= count_r + IW'(1);
        end
        C_WALK_INIT: steps_r <= IW'(walk_k - CW'(1));
        C_WALK:      steps_r <= steps_r - IW'(1);
        C_INS_B:     free_r <= lk_rdata;
        C_INS_C:     count_r <= count_r + IW'(1);
        C_DEL_B:     if (del_head_r) head_r <= lk_rdata;
        C_DEL_C: begin
          free_r  <= aux_r;
          count_r <= count_r - IW'(1);
        end
        default: ;
      endcase
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    case (cmd)
      C_ACCEPT: begin
        req_r <= in_req_type;
        val_r <= in_item_value;
        pos_r <= in_position;
      end
      C_FINISH: begin
        status_r  <= err;
        removed_r <= '0;
        len_r     <= 6'(count_r);
      end
      C_INS_HEAD: begin
        status_r  <= ST_OK;
        removed_r <= '0;
        len_r     <= 6'(count_r + IW'(1));
      end
      C_WALK_INIT: cur_r <= head_r;
      C_WALK:      cur_r <= lk_rdata;
      C_INS_A:     aux_r <= lk_rdata;
      C_INS_B:     aux_r <= free_r;
      C_INS_C: begin
        status_r  <= ST_OK;
        removed_r <= '0;
        len_r     <= 6'(count_r + IW'(1));
      end
      C_DEL_H: begin
        aux_r      <= head_r;
        del_head_r <= 1'b1;
      end
      C_DEL_A: begin
        aux_r      <= lk_rdata;
        del_head_r <= 1'b0;
      end
      C_DEL_C: begin
        status_r  <= ST_OK;
        removed_r <= dt_rdata;
        len_r     <= 6'(count_r - IW'(1));
      end
      default: ;
    endcase
  end

  assign out_status        = status_r;
  assign out_removed_value = removed_r;
  assign out_list_length   = len_r;

endmodule
`default_nettype wire
